@@ rtl/iec_pkg.sv @@
// Shared types and constants for the incremental edge coloring core.
// Used by iec_node_store, iec_edge_scan and incremental_edge_coloring_core.
package iec_pkg;

    localparam int NODE_COUNT_DEF    = 1024;
    localparam int EDGE_CAPACITY_DEF = 1024;
    localparam int COLOR_COUNT_DEF   = 16;

    localparam int ID_W     = 10;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int COLOR_W  = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_MARK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_ADDED       = 3'd0,
        RES_DUP         = 3'd1,
        RES_REMOVED     = 3'd2,
        RES_ABSENT      = 3'd3,
        RES_BOTH_REPEAT = 3'd4,
        RES_NO_COLOR    = 3'd5,
        RES_FULL_MARKED = 3'd6
    } res_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_RDA,
        S_RDB,
        S_CAPB,
        S_SCAN,
        S_DECIDE,
        S_WRA,
        S_WRB,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic done;
        logic found;
        logic full;
    } scan_stat_t;

endpackage

@@ rtl/iec_node_store.sv @@
// Per-node store: used-color mask and repeat-allowed flag, one synchronous RAM.
// Runs a clearing pass after reset. Depends on iec_pkg.
module iec_node_store #(
    parameter int NODE_COUNT  = iec_pkg::NODE_COUNT_DEF,
    parameter int COLOR_COUNT = iec_pkg::COLOR_COUNT_DEF,
    localparam int NIW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1,
    localparam int NDW = COLOR_COUNT + 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [NIW-1:0] rd_addr,
    output logic [NDW-1:0] rd_data,
    input  logic           wr_en,
    input  logic [NIW-1:0] wr_addr,
    input  logic [NDW-1:0] wr_data,
    output logic           ready
);
    import iec_pkg::*;

    logic [NDW-1:0] mem [NODE_COUNT];
    logic [NDW-1:0] rd_data_reg;
    logic [NIW-1:0] clr_idx_reg;
    logic           clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clr_busy_reg) begin
            if (clr_idx_reg == NIW'(NODE_COUNT - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_idx_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clr_busy_reg;

endmodule

@@ rtl/iec_edge_scan.sv @@
// Edge table RAM with a linear search over the filled region (high-water mark).
// Finds the matching edge and the lowest free slot. Depends on iec_pkg.
module iec_edge_scan #(
    parameter int EDGE_CAPACITY = iec_pkg::EDGE_CAPACITY_DEF,
    parameter int NIW           = iec_pkg::ID_W,
    parameter int CW            = iec_pkg::COLOR_W,
    localparam int EIW  = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1,
    localparam int CNTW = $clog2(EDGE_CAPACITY + 1),
    localparam int EW   = 1 + 2 * NIW + CW
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NIW-1:0]      lo,
    input  logic [NIW-1:0]      hi,
    input  logic                ins_en,
    input  logic [CW-1:0]       ins_color,
    input  logic                del_en,
    output iec_pkg::scan_stat_t stat,
    output logic [CW-1:0]       found_color
);
    import iec_pkg::*;

    logic [EW-1:0]   mem [EDGE_CAPACITY];
    logic [EW-1:0]   rd_data_reg;
    logic [CNTW-1:0] hwm_reg;
    logic [CNTW-1:0] scan_cnt_reg;
    logic            busy_reg;
    logic            pend_reg;
    logic [EIW-1:0]  pend_idx_reg;
    logic            found_reg;
    logic [EIW-1:0]  found_idx_reg;
    logic [CW-1:0]   found_color_reg;
    logic            free_found_reg;
    logic [EIW-1:0]  free_idx_reg;

    logic            issue;
    logic [EIW-1:0]  rd_addr;
    logic            ent_valid;
    logic [NIW-1:0]  ent_lo;
    logic [NIW-1:0]  ent_hi;
    logic [CW-1:0]   ent_color;
    logic [EIW-1:0]  slot;
    logic            wr_en;
    logic [EIW-1:0]  wr_addr;
    logic [EW-1:0]   wr_data;

    assign issue   = busy_reg && (scan_cnt_reg < hwm_reg);
    assign rd_addr = scan_cnt_reg[EIW-1:0];
    assign {ent_valid, ent_lo, ent_hi, ent_color} = rd_data_reg;
    assign slot    = free_found_reg ? free_idx_reg : hwm_reg[EIW-1:0];

    always_comb begin
        wr_en   = ins_en || del_en;
        wr_addr = ins_en ? slot : found_idx_reg;
        wr_data = ins_en ? {1'b1, lo, hi, ins_color} : '0;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            hwm_reg  <= '0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                pend_reg <= 1'b0;
            end else if (busy_reg) begin
                pend_reg <= issue;
                if (!issue && !pend_reg) begin
                    busy_reg <= 1'b0;
                end
            end
            if (ins_en && !free_found_reg) begin
                hwm_reg <= hwm_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            scan_cnt_reg   <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (busy_reg) begin
            if (issue) begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
                pend_idx_reg <= rd_addr;
            end
            if (pend_reg) begin
                if (ent_valid && ent_lo == lo && ent_hi == hi && !found_reg) begin
                    found_reg       <= 1'b1;
                    found_idx_reg   <= pend_idx_reg;
                    found_color_reg <= ent_color;
                end
                if (!ent_valid && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= pend_idx_reg;
                end
            end
        end
    end

    always_comb begin
        stat.done  = busy_reg && !issue && !pend_reg;
        stat.found = found_reg;
        stat.full  = !free_found_reg && (hwm_reg == CNTW'(EDGE_CAPACITY));
    end

    assign found_color = found_color_reg;

endmodule

@@ rtl/incremental_edge_coloring_core.sv @@
// Incremental first-fit edge coloring core: control sequencer, node store and edge table.
// Depends on iec_pkg, iec_node_store and iec_edge_scan.
// A transaction steps through id reduction, the two endpoint mask reads, an edge table
// search for add and remove only, the decision, the two mask write-backs and the output;
// the table is searched linearly over the slots below the high-water mark through one RAM
// read port, and the two endpoint masks are read and written back through the node RAM
// port. Node ids at or above NODE_COUNT are reduced by a reciprocal multiply and a subtract
// step. The result waits in one output register; a transaction whose result is ready
// stalls while the previous one is not taken.
// After reset the node RAM is cleared before the first input is taken.
module incremental_edge_coloring_core #(
    parameter int NODE_COUNT    = iec_pkg::NODE_COUNT_DEF,
    parameter int EDGE_CAPACITY = iec_pkg::EDGE_CAPACITY_DEF,
    parameter int COLOR_COUNT   = iec_pkg::COLOR_COUNT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [iec_pkg::OP_W-1:0]     s_opcode,
    input  logic [iec_pkg::ID_W-1:0]     s_id_a,
    input  logic [iec_pkg::ID_W-1:0]     s_id_b,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [iec_pkg::STATUS_W-1:0] m_status,
    output logic [iec_pkg::COLOR_W-1:0]  m_edge_color,
    output logic [iec_pkg::COLOR_W-1:0]  m_max_color
);
    import iec_pkg::*;

    localparam int NIW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CW  = $clog2(COLOR_COUNT);
    localparam int NDW = COLOR_COUNT + 1;
    localparam int RW  = 17;
    localparam int QS  = ID_W + NIW + 1;
    localparam int RMW = ID_W + 2;
    localparam int PW  = ID_W + RMW;
    localparam int RM  = (1 << QS) / NODE_COUNT;

    fsm_t state_reg, state_next;
    op_t  op_reg, op_next;
    logic [ID_W-1:0]        a_reg, a_next, b_reg, b_next;
    logic [ID_W-1:0]        qa_reg, qa_next, qb_reg, qb_next;
    logic [NDW-1:0]         na_reg, na_next, nb_reg, nb_next;
    logic [NDW-1:0]         newa_reg, newa_next, newb_reg, newb_next;
    logic                   wa_reg, wa_next, wb_reg, wb_next;
    res_t                   res_reg, res_next;
    logic [CW-1:0]          rcol_reg, rcol_next;
    logic [CW-1:0]          highest_reg, highest_next;
    logic                   m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;
    logic [COLOR_W-1:0]     m_color_reg, m_color_next, m_max_reg, m_max_next;

    logic [NIW-1:0]         ia, ib, lo, hi;
    logic [NIW-1:0]         node_raddr, node_waddr;
    logic [NDW-1:0]         node_rdata, node_wdata;
    logic                   node_we, node_ready;
    logic                   scan_start, ins_en, del_en;
    scan_stat_t             scan_stat;
    logic [CW-1:0]          found_color;
    logic                   fa, fb;
    logic [COLOR_COUNT-1:0] used;
    logic [COLOR_COUNT-1:0] cbit, fbit;
    logic [CW-1:0]          ffc;
    logic                   ffok;
    logic                   a_big, b_big;
    logic [PW-1:0]          qa_prod, qb_prod;

    assign ia = NIW'(a_reg);
    assign ib = NIW'(b_reg);
    assign lo = (a_reg < b_reg) ? ia : ib;
    assign hi = (a_reg < b_reg) ? ib : ia;
    assign fa = na_reg[COLOR_COUNT];
    assign fb = nb_reg[COLOR_COUNT];
    assign a_big = RW'(a_reg) >= RW'(NODE_COUNT);
    assign b_big = RW'(b_reg) >= RW'(NODE_COUNT);

    // quotient estimate, never above the true quotient and at most one below
    assign qa_prod = PW'(s_id_a) * PW'(RM);
    assign qb_prod = PW'(s_id_b) * PW'(RM);

    iec_node_store #(
        .NODE_COUNT (NODE_COUNT),
        .COLOR_COUNT(COLOR_COUNT)
    ) u_node (
        .aclk   (aclk),
        .aresetn(aresetn),
        .rd_addr(node_raddr),
        .rd_data(node_rdata),
        .wr_en  (node_we),
        .wr_addr(node_waddr),
        .wr_data(node_wdata),
        .ready  (node_ready)
    );

    iec_edge_scan #(
        .EDGE_CAPACITY(EDGE_CAPACITY),
        .NIW          (NIW),
        .CW           (CW)
    ) u_edge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (scan_start),
        .lo         (lo),
        .hi         (hi),
        .ins_en     (ins_en),
        .ins_color  (ffc),
        .del_en     (del_en),
        .stat       (scan_stat),
        .found_color(found_color)
    );

    always_comb begin
        used = (fa ? '0 : na_reg[COLOR_COUNT-1:0]) | (fb ? '0 : nb_reg[COLOR_COUNT-1:0]);
        ffc  = '0;
        ffok = 1'b0;
        for (int c = COLOR_COUNT - 1; c >= 0; c--) begin
            if (!used[c]) begin
                ffc  = CW'(c);
                ffok = 1'b1;
            end
        end
        cbit = {{(COLOR_COUNT-1){1'b0}}, 1'b1} << ffc;
        fbit = {{(COLOR_COUNT-1){1'b0}}, 1'b1} << found_color;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            highest_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            highest_reg <= highest_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        qa_reg       <= qa_next;
        qb_reg       <= qb_next;
        na_reg       <= na_next;
        nb_reg       <= nb_next;
        newa_reg     <= newa_next;
        newb_reg     <= newb_next;
        wa_reg       <= wa_next;
        wb_reg       <= wb_next;
        res_reg      <= res_next;
        rcol_reg     <= rcol_next;
        m_status_reg <= m_status_next;
        m_color_reg  <= m_color_next;
        m_max_reg    <= m_max_next;
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        qa_next       = qa_reg;
        qb_next       = qb_reg;
        na_next       = na_reg;
        nb_next       = nb_reg;
        newa_next     = newa_reg;
        newb_next     = newb_reg;
        wa_next       = wa_reg;
        wb_next       = wb_reg;
        res_next      = res_reg;
        rcol_next     = rcol_reg;
        highest_next  = highest_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_color_next  = m_color_reg;
        m_max_next    = m_max_reg;
        s_ready       = 1'b0;
        node_raddr    = ia;
        node_we       = 1'b0;
        node_waddr    = ia;
        node_wdata    = newa_reg;
        scan_start    = 1'b0;
        ins_en        = 1'b0;
        del_en        = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                if (node_ready) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = op_t'(s_opcode);
                    a_next     = s_id_a;
                    b_next     = s_id_b;
                    qa_next    = ID_W'(qa_prod >> QS);
                    qb_next    = ID_W'(qb_prod >> QS);
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (a_big) begin
                    a_next = a_reg - ID_W'(qa_reg * NODE_COUNT);
                end
                if (b_big) begin
                    b_next = b_reg - ID_W'(qb_reg * NODE_COUNT);
                end
                qa_next = ID_W'(1);
                qb_next = ID_W'(1);
                if (!a_big && !b_big) begin
                    state_next = S_RDA;
                end
            end
            S_RDA: begin
                node_raddr = ia;
                state_next = S_RDB;
            end
            S_RDB: begin
                node_raddr = ib;
                na_next    = node_rdata;
                state_next = S_CAPB;
            end
            S_CAPB: begin
                nb_next = node_rdata;
                if (op_reg == OP_ADD || op_reg == OP_REMOVE) begin
                    scan_start = 1'b1;
                    state_next = S_SCAN;
                end else begin
                    state_next = S_DECIDE;
                end
            end
            S_SCAN: begin
                if (scan_stat.done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                wa_next    = 1'b0;
                wb_next    = 1'b0;
                rcol_next  = '0;
                res_next   = RES_ABSENT;
                state_next = S_WRA;
                case (op_reg)
                    OP_ADD: begin
                        if (scan_stat.found) begin
                            res_next  = RES_DUP;
                            rcol_next = found_color;
                        end else if (fa && fb) begin
                            res_next = RES_BOTH_REPEAT;
                        end else if (!ffok) begin
                            res_next = RES_NO_COLOR;
                        end else if (scan_stat.full) begin
                            res_next = RES_FULL_MARKED;
                        end else begin
                            res_next  = RES_ADDED;
                            rcol_next = ffc;
                            ins_en    = 1'b1;
                            wa_next   = 1'b1;
                            wb_next   = 1'b1;
                            newa_next = {fa, na_reg[COLOR_COUNT-1:0] | cbit};
                            newb_next = {fb, nb_reg[COLOR_COUNT-1:0] | cbit};
                            if (ffc > highest_reg) begin
                                highest_next = ffc;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (scan_stat.found) begin
                            res_next  = RES_REMOVED;
                            rcol_next = found_color;
                            del_en    = 1'b1;
                            wa_next   = 1'b1;
                            wb_next   = 1'b1;
                            newa_next = {fa, na_reg[COLOR_COUNT-1:0] & ~fbit};
                            newb_next = {fb, nb_reg[COLOR_COUNT-1:0] & ~fbit};
                        end
                    end
                    OP_MARK: begin
                        res_next  = RES_FULL_MARKED;
                        wa_next   = !fa;
                        newa_next = {1'b1, na_reg[COLOR_COUNT-1:0]};
                    end
                    default: begin
                        res_next = RES_ABSENT;
                    end
                endcase
            end
            S_WRA: begin
                node_we    = wa_reg;
                node_waddr = ia;
                node_wdata = newa_reg;
                state_next = S_WRB;
            end
            S_WRB: begin
                node_we    = wb_reg;
                node_waddr = ib;
                node_wdata = newb_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_reg;
                    m_color_next  = COLOR_W'(rcol_reg);
                    m_max_next    = COLOR_W'(highest_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_edge_color = m_color_reg;
    assign m_max_color  = m_max_reg;

    a_accept_to_reduce: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_REDUCE)
        else $error("accepted transaction did not start id reduction");

    a_single_edge_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ins_en && del_en))
        else $error("insert and delete in the same cycle");

    a_highest_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> highest_reg >= $past(highest_reg))
        else $error("highest color decreased");

    a_node_write_late: assert property (@(posedge aclk) disable iff (!aresetn)
        node_we |-> (state_reg == S_WRA || state_reg == S_WRB))
        else $error("node write outside write-back");

endmodule

@@ bench/incremental_edge_coloring_core_tb.sv @@
// Self-checking bench for incremental_edge_coloring_core: a scoreboard class predicts
// first-fit colors and status per transaction; tasks drive random and directed traffic.
// Depends on iec_pkg and the core RTL.
module incremental_edge_coloring_core_tb;
    import iec_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TABLE_SLOTS    = EDGE_CAPACITY_DEF;

    class coloring_scoreboard;
        logic [15:0]        node_mask [NODE_COUNT_DEF];
        bit                 node_flag [NODE_COUNT_DEF];
        logic [COLOR_W-1:0] edge_col [bit [2*ID_W-1:0]];
        logic [COLOR_W-1:0] top_color;
        logic [STATUS_W+2*COLOR_W-1:0] pending [$];
        int errors;

        function new();
            foreach (node_mask[i]) begin
                node_mask[i] = '0;
                node_flag[i] = 0;
            end
            top_color = '0;
            errors = 0;
        endfunction

        function void note_input(op_t op, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
            logic [ID_W-1:0]     lo, hi;
            bit [2*ID_W-1:0]     key;
            res_t                st;
            logic [COLOR_W-1:0]  col;
            logic [15:0]         used;
            int                  c;
            logic [STATUS_W+2*COLOR_W-1:0] entry;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            key = {lo, hi};
            st = RES_ABSENT;
            col = '0;
            case (op)
                OP_ADD: begin
                    if (edge_col.exists(key)) begin
                        st = RES_DUP;
                        col = edge_col[key];
                    end else if (node_flag[a] && node_flag[b]) begin
                        st = RES_BOTH_REPEAT;
                    end else begin
                        used = '0;
                        if (!node_flag[a]) used |= node_mask[a];
                        if (!node_flag[b]) used |= node_mask[b];
                        c = 0;
                        while (c < COLOR_COUNT_DEF && used[c]) c++;
                        if (c >= COLOR_COUNT_DEF) begin
                            st = RES_NO_COLOR;
                        end else if (edge_col.num() >= TABLE_SLOTS) begin
                            st = RES_FULL_MARKED;
                        end else begin
                            node_mask[a][c] = 1'b1;
                            node_mask[b][c] = 1'b1;
                            if (c > top_color) top_color = COLOR_W'(c);
                            edge_col[key] = COLOR_W'(c);
                            st = RES_ADDED;
                            col = COLOR_W'(c);
                        end
                    end
                end
                OP_REMOVE: begin
                    if (edge_col.exists(key)) begin
                        col = edge_col[key];
                        node_mask[a][col] = 1'b0;
                        node_mask[b][col] = 1'b0;
                        edge_col.delete(key);
                        st = RES_REMOVED;
                    end
                end
                OP_MARK: begin
                    node_flag[a] = 1;
                    st = RES_FULL_MARKED;
                end
                default: st = RES_ABSENT;
            endcase
            entry = {st, col, top_color};
            pending = {pending, entry};
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [COLOR_W-1:0] col,
                                   logic [COLOR_W-1:0] mx);
            logic [STATUS_W-1:0] e_st;
            logic [COLOR_W-1:0]  e_col, e_mx;
            if (pending.size() == 0) begin
                $error("unexpected result transaction: status %0d", st);
                errors++;
                return;
            end
            {e_st, e_col, e_mx} = pending.pop_front();
            if (st !== e_st) begin
                $error("status expected %0d actual %0d", e_st, st);
                errors++;
            end
            if (col !== e_col) begin
                $error("edge_color expected %0d actual %0d", e_col, col);
                errors++;
            end
            if (mx !== e_mx) begin
                $error("max_color expected %0d actual %0d", e_mx, mx);
                errors++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_opcode = '0;
    logic [ID_W-1:0]     s_id_a = '0;
    logic [ID_W-1:0]     s_id_b = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [COLOR_W-1:0]  m_edge_color;
    logic [COLOR_W-1:0]  m_max_color;

    coloring_scoreboard sb = new();
    int idle_send = 0;
    int idle_recv = 0;
    int stall_count = 0;

    incremental_edge_coloring_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(s_opcode), .s_id_a(s_id_a), .s_id_b(s_id_b),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_edge_color(m_edge_color), .m_max_color(m_max_color)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom % 100) >= idle_recv;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(op_t'(s_opcode), s_id_a, s_id_b);
            if (m_valid && m_ready) sb.check_result(m_status, m_edge_color, m_max_color);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_count <= 0;
            end else if (stall_count >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                stall_count <= stall_count + 1;
            end
        end
    end

    task automatic send_op(op_t op, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
        @(negedge aclk);
        while (($urandom % 100) < idle_send) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_opcode = op;
        s_id_a   = a;
        s_id_b   = b;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [ID_W-1:0] pick_node();
        if ($urandom_range(0, 99) < 85) return ID_W'($urandom_range(0, 19));
        return ID_W'($urandom_range(0, 1023));
    endfunction

    task automatic random_ops(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60)      send_op(OP_ADD, pick_node(), pick_node());
            else if (r < 90) send_op(OP_REMOVE, pick_node(), pick_node());
            else if (r < 93) send_op(OP_MARK, ID_W'($urandom_range(0, 1023)),
                                     ID_W'($urandom_range(0, 1023)));
            else             send_op(OP_NONE, ID_W'($urandom_range(0, 1023)),
                                     ID_W'($urandom_range(0, 1023)));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_op(OP_ADD, 10'd0, 10'd1023);
        send_op(OP_ADD, 10'd1023, 10'd0);
        send_op(OP_ADD, 10'd5, 10'd5);
        send_op(OP_ADD, 10'd0, 10'd5);
        send_op(OP_ADD, 10'd5, 10'd1023);
        send_op(OP_REMOVE, 10'd1023, 10'd0);
        send_op(OP_REMOVE, 10'd1023, 10'd0);
        send_op(OP_REMOVE, 10'd600, 10'd601);
        send_op(OP_MARK, 10'd7, 10'd1023);
        send_op(OP_MARK, 10'd7, 10'd0);
        send_op(OP_MARK, 10'd8, 10'd8);
        send_op(OP_ADD, 10'd7, 10'd8);
        send_op(OP_ADD, 10'd7, 10'd5);
        send_op(OP_ADD, 10'd8, 10'd5);
        send_op(OP_ADD, 10'd7, 10'd7);
        send_op(OP_ADD, 10'd0, 10'd1023);
        send_op(OP_REMOVE, 10'd5, 10'd5);
        send_op(OP_NONE, 10'd1023, 10'd1023);
        send_op(OP_NONE, 10'd0, 10'd0);

        idle_send = 20; idle_recv = 45;
        random_ops(150);
        idle_send = 45; idle_recv = 20;
        random_ops(150);
        idle_send = 0; idle_recv = 0;
        random_ops(150);

        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
